>>> hdl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	// packet layout
	localparam logic [15:0] HDR_BYTES   = 16'd4;
	localparam logic [15:0] POS_HEADER  = 16'd0;
	localparam logic [15:0] POS_TYPE    = 16'd1;
	localparam logic [15:0] POS_LEN_LO  = 16'd2;
	localparam logic [15:0] POS_LEN_HI  = 16'd3;

	// configuration registers
	localparam int unsigned ADDR_W = 3;
	localparam logic        REG_EXPECTED_HEADER = 1'b0;
	localparam logic [7:0]  EXPECTED_HEADER_RST = 8'd247;

	// one received byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       clear;
	} in_item_t;

	// one byte passed on with its framing marks
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] position;
		logic        is_first;
		logic        is_last;
		logic        error;
	} out_item_t;

	// parser state carried between bytes
	typedef struct packed {
		logic [15:0] byte_position;
		logic [15:0] packet_length;
		logic        error_flag;
	} parse_state_t;

	localparam parse_state_t PARSE_STATE_RST = '{
		byte_position: 16'd0,
		packet_length: 16'd0,
		error_flag:    1'b0
	};

endpackage

>>> hdl/lpd_stream_if.sv
// ----------------------------------------------------------------------------
// lpd_stream_if
// Valid/ready stream channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface lpd_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

>>> hdl/length_prefixed_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_top
// Cuts a byte stream into length-prefixed packets and tags every byte.
//
//   channel  dir  payload                                       transfer when
//   rx       in   data_byte[7:0], clear                         valid & ready
//   tx       out  out_byte[7:0], position[15:0], is_first,      valid & ready
//                 is_last, error
//   apb      in   expected_header at byte address 0             psel&penable&pwrite
//
// One byte per cycle unless tx stalls a waiting result; each byte's result is
// registered into the output register on its transfer, set by a single compare-and-count step.
// rx.ready is low only while a result waits in the output register and tx is
// stalled. arst_n clears the parser state, the output valid and restores
// expected_header to 247.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	lpd_stream_if.sink                 rx,
	lpd_stream_if.source               tx
);
	import lpd_pkg::*;

	logic [7:0]   expected_header_q;
	parse_state_t state_q;
	parse_state_t next_state;
	out_item_t    result;
	out_item_t    result_q;
	logic         result_valid_q;
	logic         rx_xfer;
	logic         cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[ADDR_W-1] == REG_EXPECTED_HEADER) ?
		{24'd0, expected_header_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_header_q <= EXPECTED_HEADER_RST;
		end else if (cfg_wr && (paddr[ADDR_W-1] == REG_EXPECTED_HEADER)) begin
			expected_header_q <= pwdata[7:0];
		end
	end

	// framing logic
	lpd_parse u_parse (
		.item            (rx.item),
		.state           (state_q),
		.expected_header (expected_header_q),
		.result          (result),
		.next_state      (next_state)
	);

	// accept while the output register is empty or being drained
	assign rx.ready = !result_valid_q || tx.ready;
	assign rx_xfer  = rx.valid && rx.ready;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_STATE_RST;
		end else if (rx_xfer) begin
			state_q <= next_state;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rx_xfer) begin
			result_valid_q <= 1'b1;
		end else if (tx.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_xfer) begin
			result_q <= result;
		end
	end

	assign tx.valid = result_valid_q;
	assign tx.item  = result_q;

endmodule

>>> hdl/lpd_parse.sv
// ----------------------------------------------------------------------------
// lpd_parse
// Per-byte framing decision: result fields and next parser state.
// ----------------------------------------------------------------------------
module lpd_parse (
	input  lpd_pkg::in_item_t     item,
	input  lpd_pkg::parse_state_t state,
	input  logic [7:0]            expected_header,
	output lpd_pkg::out_item_t    result,
	output lpd_pkg::parse_state_t next_state
);
	import lpd_pkg::*;

	parse_state_t cur;
	logic [16:0]  pos_inc;
	logic [15:0]  full_len;

	// clear restarts the parser before this byte
	assign cur      = item.clear ? PARSE_STATE_RST : state;
	assign pos_inc  = {1'b0, cur.byte_position} + 17'd1;
	assign full_len = {item.data_byte, cur.packet_length[7:0]};

	always_comb begin
		next_state      = cur;
		result.out_byte = item.data_byte;
		result.position = cur.byte_position;
		result.is_first = 1'b0;
		result.is_last  = 1'b0;
		result.error    = 1'b0;
		if (cur.error_flag) begin
			result.position = 16'd0;
			result.error    = 1'b1;
		end else begin
			unique case (cur.byte_position)
				POS_HEADER: begin
					if (item.data_byte != expected_header) begin
						next_state.error_flag = 1'b1;
						result.error          = 1'b1;
					end else begin
						result.is_first          = 1'b1;
						next_state.byte_position = POS_TYPE;
					end
				end
				POS_TYPE: begin
					next_state.byte_position = POS_LEN_LO;
				end
				POS_LEN_LO: begin
					next_state.packet_length = {8'd0, item.data_byte};
					next_state.byte_position = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					next_state.packet_length = full_len;
					if (full_len < HDR_BYTES) begin
						next_state.error_flag = 1'b1;
						result.error          = 1'b1;
					end else if (full_len == HDR_BYTES) begin
						result.is_last           = 1'b1;
						next_state.byte_position = POS_HEADER;
					end else begin
						next_state.byte_position = HDR_BYTES;
					end
				end
				default: begin
					// payload bytes: last when the count reaches the length
					if (pos_inc >= {1'b0, cur.packet_length}) begin
						result.is_last           = 1'b1;
						next_state.byte_position = POS_HEADER;
					end else begin
						next_state.byte_position = pos_inc[15:0];
					end
				end
			endcase
		end
	end

endmodule

>>> verif/lpd_frame_checker.sv
// ----------------------------------------------------------------------------
// lpd_frame_checker
// Watches the rx, tx and register ports of the deframer, predicts the tagged
// byte for every rx transfer and compares it with the tx transfers in order.
// ----------------------------------------------------------------------------
module lpd_frame_checker
	import lpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              rx_valid,
	input  logic              rx_ready,
	input  in_item_t          rx_item,
	input  logic              tx_valid,
	input  logic              tx_ready,
	input  out_item_t         tx_item,
	output int unsigned       fail_count,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ADDR_W-1:0] ADDR_EXPECTED_HEADER = {REG_EXPECTED_HEADER, 2'b00};

	logic [7:0]   header_value = EXPECTED_HEADER_RST;
	parse_state_t parse = PARSE_STATE_RST;
	out_item_t    tagged_bytes [$];
	int unsigned  fails = 0;
	int unsigned  waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	// tag one received byte and advance the parser copy
	function automatic out_item_t tag_byte(input in_item_t rcv);
		out_item_t   res;
		logic [15:0] pos;
		if (rcv.clear)
			parse = PARSE_STATE_RST;
		res.out_byte = rcv.data_byte;
		res.position = 16'd0;
		res.is_first = 1'b0;
		res.is_last  = 1'b0;
		res.error    = 1'b1;
		if (parse.error_flag)
			return res;
		pos = parse.byte_position;
		res.position = pos;
		res.error    = 1'b0;
		case (pos)
			POS_HEADER: begin
				if (rcv.data_byte != header_value) begin
					parse.error_flag = 1'b1;
					res.error = 1'b1;
					return res;
				end
				res.is_first = 1'b1;
				parse.byte_position = POS_TYPE;
			end
			POS_TYPE: begin
				parse.byte_position = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				parse.packet_length = {8'h00, rcv.data_byte};
				parse.byte_position = POS_LEN_HI;
			end
			POS_LEN_HI: begin
				parse.packet_length = {rcv.data_byte, parse.packet_length[7:0]};
				// short length poisons the stream
				if (parse.packet_length < HDR_BYTES) begin
					parse.error_flag = 1'b1;
					res.error = 1'b1;
					return res;
				end
				if (parse.packet_length == HDR_BYTES) begin
					res.is_last = 1'b1;
					parse.byte_position = POS_HEADER;
				end else begin
					parse.byte_position = HDR_BYTES;
				end
			end
			default: begin
				// payload byte, wrap to header once the length is used up
				if ({1'b0, pos} + 17'd1 >= {1'b0, parse.packet_length}) begin
					res.is_last = 1'b1;
					parse.byte_position = POS_HEADER;
				end else begin
					parse.byte_position = pos + 16'd1;
				end
			end
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// register writes, result compare, then prediction of the new transfer
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			header_value = EXPECTED_HEADER_RST;
			parse = PARSE_STATE_RST;
			tagged_bytes.delete();
			waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_EXPECTED_HEADER)
				header_value = pwdata[7:0];
			if (tx_valid && tx_ready) begin
				if (tagged_bytes.size() == 0) begin
					$error("tx transfer with nothing outstanding: out_byte %0h",
						tx_item.out_byte);
					fails++;
				end else begin
					want = tagged_bytes.pop_front();
					check_field("out_byte", want.out_byte, tx_item.out_byte);
					check_field("position", want.position, tx_item.position);
					check_field("is_first", want.is_first, tx_item.is_first);
					check_field("is_last", want.is_last, tx_item.is_last);
					check_field("error", want.error, tx_item.error);
				end
			end
			if (rx_valid && rx_ready)
				tagged_bytes.insert(tagged_bytes.size(), tag_byte(rx_item));
			waiting = tagged_bytes.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the packet deframer with directed framing cases, then random packet
// streams under several expected headers, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_EXPECTED_HEADER = {REG_EXPECTED_HEADER, 2'b00};
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned PHASE_BYTES  = 470;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int unsigned       fail_count;
	int unsigned       pending;

	logic              idle_on = 1'b1;
	logic              need_clear = 1'b0;
	logic [7:0]        cur_header = EXPECTED_HEADER_RST;
	int unsigned       byte_count = 0;
	int unsigned       cycle_count = 0;

	// opening cases, bit 8 is the clear flag
	logic [8:0] opening_seq [25] = '{
		// minimum length packet
		9'h0F7, 9'h000, 9'h004, 9'h000,
		// one payload byte, all-ones type and data
		9'h0F7, 9'h0FF, 9'h005, 9'h000, 9'h0FF,
		// bad header, then a byte while in error
		9'h000, 9'h055,
		// clear, length of three, then a byte while in error
		9'h1F7, 9'h07E, 9'h003, 9'h000, 9'h0A5,
		// clear, zero length
		9'h1F7, 9'h001, 9'h000, 9'h000,
		// clear, then clear again inside the payload
		9'h1F7, 9'h002, 9'h006, 9'h000, 9'h111
	};

	lpd_stream_if #(.item_t(in_item_t))  rx_if ();
	lpd_stream_if #(.item_t(out_item_t)) tx_if ();

	length_prefixed_packet_deframer_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_if),
		.tx      (tx_if)
	);

	lpd_frame_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.rx_valid   (rx_if.valid),
		.rx_ready   (rx_if.ready),
		.rx_item    (rx_if.item),
		.tx_valid   (tx_if.valid),
		.tx_ready   (tx_if.ready),
		.tx_item    (tx_if.item),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// tx back-pressure
	always @(negedge clk) begin
		tx_if.ready <= !idle_on || ($urandom_range(0, 99) >= 14);
	end

	// one rx transfer, called and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic clr);
		if (idle_on && $urandom_range(0, 99) < 12) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.item  <= '{data_byte: b, clear: clr};
		do @(posedge clk); while (!rx_if.ready);
		@(negedge clk);
		byte_count++;
	endtask

	// a few random bytes after a broken frame, next frame must clear
	task automatic send_junk();
		repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		need_clear = 1'b1;
	endtask

	task automatic send_frame(input logic [15:0] len, input logic clr, input logic bad_hdr,
			input int unsigned mid_clear_permille);
		logic [7:0] hdr;
		hdr = bad_hdr ? cur_header ^ 8'($urandom_range(1, 255)) : cur_header;
		send_byte(hdr, clr);
		if (bad_hdr) begin
			send_junk();
			return;
		end
		send_byte(8'($urandom), 1'b0);
		send_byte(len[7:0], 1'b0);
		send_byte(len[15:8], 1'b0);
		if (len < HDR_BYTES) begin
			send_junk();
			return;
		end
		for (int unsigned k = HDR_BYTES; k < len; k++) begin
			// occasional new connection in the middle of a payload
			if ($urandom_range(0, 999) < mid_clear_permille) begin
				send_byte(8'($urandom), 1'b1);
				need_clear = 1'b1;
				return;
			end
			send_byte(8'($urandom), 1'b0);
		end
	endtask

	task automatic send_random_frame();
		int unsigned pick;
		logic        clr;
		pick = $urandom_range(0, 99);
		clr = need_clear || ($urandom_range(0, 19) == 0);
		need_clear = 1'b0;
		if (pick < 6)
			send_frame(16'($urandom), clr, 1'b1, 0);
		else if (pick < 11)
			send_frame(16'($urandom_range(0, 3)), clr, 1'b0, 0);
		else if (pick < 14) begin
			send_byte(8'($urandom), clr);
			send_junk();
		end else if ($urandom_range(0, 19) == 0)
			send_frame(16'($urandom_range(21, 300)), clr, 1'b0, 10);
		else
			send_frame(16'($urandom_range(4, 20)), clr, 1'b0, 10);
	endtask

	// hold rx until every byte has come out of tx
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_header(input logic [7:0] h);
		wait_drained();
		repeat (3) @(negedge clk);
		apb_write(ADDR_EXPECTED_HEADER, {24'h000000, h});
		cur_header = h;
	endtask

	// stimulus and verdict
	initial begin
		logic [7:0]  phase_hdr [4];
		int unsigned phase_end;
		int unsigned half_way;
		logic        paused;
		rx_if.valid = 1'b0;
		rx_if.item  = '0;
		tx_if.ready = 1'b0;
		phase_hdr[0] = 8'h00;
		phase_hdr[1] = 8'hFF;
		phase_hdr[2] = 8'($urandom_range(1, 254));
		phase_hdr[3] = EXPECTED_HEADER_RST;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed framing cases under the reset header
		for (int i = 0; i < 25; i++)
			send_byte(opening_seq[i][7:0], opening_seq[i][8]);
		need_clear = 1'b1;

		// random packet streams, one header per phase, second phase without stalls
		for (int p = 0; p < 4; p++) begin
			set_header(phase_hdr[p]);
			idle_on = (p != 1);
			phase_end = byte_count + PHASE_BYTES;
			half_way = byte_count + PHASE_BYTES / 2;
			paused = 1'b0;
			while (byte_count < phase_end) begin
				if (!paused && byte_count >= half_way) begin
					wait_drained();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end

		// largest length field, cut short by a new connection
		send_frame(16'hFFFF, 1'b1, 1'b0, 1000);

		wait_drained();
		repeat (5) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> length_prefixed_packet_deframer_top.f
hdl/lpd_pkg.sv
hdl/lpd_stream_if.sv
hdl/lpd_parse.sv
hdl/length_prefixed_packet_deframer_top.sv
verif/lpd_frame_checker.sv
verif/tb_top.sv
